[rtl/stxfrd_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, status codes and types of the STX frame receiver.
// No dependencies; every other file of the block refers to this package.
package stxfrd_pkg;

   localparam int BYTE_W        = 8;
   localparam int LEN_W         = 5;
   localparam int SLOT_W        = 2;
   localparam int STATUS_W      = 3;
   localparam int COUNT_W       = 3;
   localparam int PAYLOAD_MAX   = 32;
   localparam int PL_ADDR_W     = $clog2(PAYLOAD_MAX);
   localparam int HANDLER_SLOTS = 4;
   localparam int NUM_CODE_REGS = 4;
   localparam int Q_DEPTH       = 2;
   localparam int Q_PTR_W       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_PAYLOAD    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_HANDLER = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CSUM_ERR   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_START_ERR  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_LEN_ERR    = 3'd5;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_START_BYTE    = 3'd0;
   localparam logic [2:0] REG_HANDLER_COUNT = 3'd1;
   localparam logic [2:0] REG_HANDLER_CODE0 = 3'd2;
   localparam logic [2:0] REG_HANDLER_CODE1 = 3'd3;
   localparam logic [2:0] REG_HANDLER_CODE2 = 3'd4;
   localparam logic [2:0] REG_HANDLER_CODE3 = 3'd5;

   typedef struct packed {
      logic [BYTE_W-1:0]                     start_byte;
      logic [COUNT_W-1:0]                    handler_count;
      logic [NUM_CODE_REGS-1:0][BYTE_W-1:0]  handler_code;
   } cfg_type;

   // one entry of the front-to-back queue
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   cmd;
      logic [SLOT_W-1:0]   slot;
      logic [LEN_W-1:0]    len;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic                 en;
      logic [PL_ADDR_W-1:0] addr;
      logic [BYTE_W-1:0]    data;
   } pl_wr_type;

endpackage

[rtl/stxfrd_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the STX frame receiver.
// Depends on stxfrd_pkg for field widths.
interface stxfrd_req_if;
   logic                          valid;
   logic                          ready;
   logic [stxfrd_pkg::BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface stxfrd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [stxfrd_pkg::STATUS_W-1:0] status;
   logic [stxfrd_pkg::BYTE_W-1:0]   data_byte;
   logic [stxfrd_pkg::BYTE_W-1:0]   frame_cmd;
   logic [stxfrd_pkg::SLOT_W-1:0]   slot_index;
   logic [stxfrd_pkg::LEN_W-1:0]    payload_len;
   logic                            last;
   modport source (output valid, output status, output data_byte, output frame_cmd,
                   output slot_index, output payload_len, output last, input ready);
   modport sink   (input valid, input status, input data_byte, input frame_cmd,
                   input slot_index, input payload_len, input last, output ready);
endinterface

[rtl/stxfrd_front.sv]
`timescale 1ns / 1ps
// Frame parser: takes bytes, checks the frame and pushes one job per frame end or error.
// Depends on stxfrd_pkg and stxfrd_req_if.
module stxfrd_front (
   input  logic                     clock,
   input  logic                     reset,
   stxfrd_req_if.sink               req_chan,
   input  stxfrd_pkg::cfg_type      cfg,
   input  stxfrd_pkg::q_status_type q_status,
   input  logic                     back_busy,
   output logic                     push_valid,
   output stxfrd_pkg::job_type      push_job,
   output stxfrd_pkg::pl_wr_type    pl_wr
);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_LEN  = 3'd1;
   localparam logic [2:0] PH_CMD  = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_SUM  = 3'd4;

   logic [2:0]                       phase_ff, phase_in;
   logic [stxfrd_pkg::LEN_W-1:0]     len_ff, len_in;
   logic [stxfrd_pkg::BYTE_W-1:0]    cmd_ff, cmd_in;
   logic [stxfrd_pkg::LEN_W-1:0]     count_ff, count_in;
   logic [stxfrd_pkg::BYTE_W-1:0]    sum_ff, sum_in;
   logic                             accept;
   logic [stxfrd_pkg::BYTE_W-1:0]    b;
   logic [stxfrd_pkg::BYTE_W-1:0]    sum_next;
   logic                             found;
   logic [stxfrd_pkg::SLOT_W-1:0]    found_slot;

   // hold payload bytes while the back end may still read the store
   assign req_chan.ready = !q_status.full &&
                           !(phase_ff == PH_DATA && (back_busy || !q_status.empty));
   assign accept   = req_chan.valid && req_chan.ready;
   assign b        = req_chan.rx_byte;
   assign sum_next = sum_ff + b;

   // lowest matching slot wins
   always_comb begin
      found      = 1'b0;
      found_slot = '0;
      for (int i = stxfrd_pkg::HANDLER_SLOTS - 1; i >= 0; i--) begin
         if (stxfrd_pkg::COUNT_W'(i) < cfg.handler_count &&
             cfg.handler_code[i] == cmd_ff) begin
            found      = 1'b1;
            found_slot = stxfrd_pkg::SLOT_W'(i);
         end
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      cmd_in     = cmd_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      push_valid = 1'b0;
      push_job   = '0;
      pl_wr      = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (b != cfg.start_byte) begin
                  push_valid      = 1'b1;
                  push_job.status = stxfrd_pkg::ST_START_ERR;
               end else begin
                  sum_in   = b;
                  len_in   = '0;
                  cmd_in   = '0;
                  count_in = '0;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (b >= stxfrd_pkg::BYTE_W'(stxfrd_pkg::PAYLOAD_MAX) ||
                   b > stxfrd_pkg::BYTE_W'(31)) begin
                  push_valid      = 1'b1;
                  push_job.status = stxfrd_pkg::ST_LEN_ERR;
                  phase_in        = PH_IDLE;
               end else begin
                  len_in   = b[stxfrd_pkg::LEN_W-1:0];
                  sum_in   = sum_next;
                  phase_in = PH_CMD;
               end
            end
            PH_CMD: begin
               cmd_in   = b;
               sum_in   = sum_next;
               count_in = '0;
               phase_in = (len_ff == '0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
               pl_wr.en   = 1'b1;
               pl_wr.addr = stxfrd_pkg::PL_ADDR_W'(count_ff);
               pl_wr.data = b;
               sum_in     = sum_next;
               count_in   = count_ff + 1'b1;
               if (count_in >= len_ff) begin
                  phase_in = PH_SUM;
               end
            end
            PH_SUM: begin
               push_valid   = 1'b1;
               phase_in     = PH_IDLE;
               push_job.cmd = cmd_ff;
               push_job.len = len_ff;
               if (b != sum_ff) begin
                  push_job.status = stxfrd_pkg::ST_CSUM_ERR;
               end else if (!found) begin
                  push_job.status = stxfrd_pkg::ST_NO_HANDLER;
               end else if (len_ff == '0) begin
                  push_job.status = stxfrd_pkg::ST_EMPTY;
                  push_job.slot   = found_slot;
               end else begin
                  push_job.status = stxfrd_pkg::ST_PAYLOAD;
                  push_job.slot   = found_slot;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         len_ff   <= '0;
         cmd_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         cmd_ff   <= cmd_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

[rtl/stxfrd_queue.sv]
`timescale 1ns / 1ps
// Short job queue between the frame parser and the result sequencer.
// Depends on stxfrd_pkg.
module stxfrd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  stxfrd_pkg::job_type      push_job,
   input  logic                     pop,
   output stxfrd_pkg::job_type      head_job,
   output stxfrd_pkg::q_status_type q_status
);

   stxfrd_pkg::job_type               entry_ff [stxfrd_pkg::Q_DEPTH];
   logic [stxfrd_pkg::Q_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [stxfrd_pkg::Q_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [stxfrd_pkg::Q_CNT_W-1:0]    count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign q_status.full  = (count_ff == stxfrd_pkg::Q_CNT_W'(stxfrd_pkg::Q_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push_valid && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_job       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == stxfrd_pkg::Q_PTR_W'(stxfrd_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == stxfrd_pkg::Q_PTR_W'(stxfrd_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/stxfrd_back.sv]
`timescale 1ns / 1ps
// Result sequencer: pops jobs, drains the payload store and drives the output register.
// Depends on stxfrd_pkg and stxfrd_rsp_if.
module stxfrd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  stxfrd_pkg::job_type      head_job,
   input  stxfrd_pkg::q_status_type q_status,
   input  stxfrd_pkg::pl_wr_type    pl_wr,
   output logic                     pop,
   output logic                     busy,
   stxfrd_rsp_if.source             rsp_chan
);

   logic [stxfrd_pkg::BYTE_W-1:0]   store [stxfrd_pkg::PAYLOAD_MAX];

   logic                            busy_ff, busy_in;
   logic [stxfrd_pkg::LEN_W-1:0]    idx_ff, idx_in;
   stxfrd_pkg::job_type             cur_ff, cur_in;
   logic                            out_valid_ff, out_valid_in;
   stxfrd_pkg::job_type             out_job_ff;
   logic                            out_last_ff;
   logic [stxfrd_pkg::BYTE_W-1:0]   out_data_ff;

   logic                            load;
   logic                            emit;
   stxfrd_pkg::job_type             sel;
   logic                            is_pl;
   logic [stxfrd_pkg::LEN_W-1:0]    rd_idx;
   logic [stxfrd_pkg::LEN_W-1:0]    rd_next;
   logic                            sel_last;

   assign load     = !out_valid_ff || rsp_chan.ready;
   assign emit     = load && (busy_ff || !q_status.empty);
   assign pop      = load && !busy_ff && !q_status.empty;
   assign busy     = busy_ff;
   assign sel      = busy_ff ? cur_ff : head_job;
   assign is_pl    = busy_ff || (head_job.status == stxfrd_pkg::ST_PAYLOAD);
   assign rd_idx   = busy_ff ? idx_ff : '0;
   assign rd_next  = rd_idx + 1'b1;
   assign sel_last = !is_pl || (rd_next == sel.len);

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = emit;
      end
      if (emit) begin
         if (is_pl && !sel_last) begin
            busy_in = 1'b1;
            idx_in  = rd_next;
            cur_in  = sel;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pl_wr.en) begin
         store[pl_wr.addr] <= pl_wr.data;
      end
   end

   // output register; payload data comes straight from the store read
   always_ff @(posedge clock) begin
      if (emit) begin
         out_job_ff  <= sel;
         out_last_ff <= sel_last;
         out_data_ff <= is_pl ? store[stxfrd_pkg::PL_ADDR_W'(rd_idx)] : '0;
      end
      idx_ff <= idx_in;
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_job_ff.status;
   assign rsp_chan.data_byte   = out_data_ff;
   assign rsp_chan.frame_cmd   = out_job_ff.cmd;
   assign rsp_chan.slot_index  = out_job_ff.slot;
   assign rsp_chan.payload_len = out_job_ff.len;
   assign rsp_chan.last        = out_last_ff;

endmodule

[rtl/stx_frame_receiver_dispatch.sv]
`timescale 1ns / 1ps
// STX frame receiver and command dispatch: top level with the APB register block.
// Throughput: 1 byte per cycle in; 1 result per cycle out if the sink is ready;
// a payload run drains back to back from the payload store. Input holds while
// the 2-entry job queue is full, and payload bytes of the next frame wait while
// a drain is queued or running.
// Reset: synchronous; resets control state and registers, payload store is not cleared.
module stx_frame_receiver_dispatch (
   input  logic                                clock,
   input  logic                                reset,
   stxfrd_req_if.sink                          req_chan,
   stxfrd_rsp_if.source                        rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [stxfrd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [stxfrd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [stxfrd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);

   stxfrd_pkg::cfg_type       cfg_ff, cfg_in;
   logic                      csr_wr;
   logic [2:0]                csr_idx;

   stxfrd_pkg::q_status_type  q_status;
   stxfrd_pkg::job_type       push_job;
   stxfrd_pkg::job_type       head_job;
   stxfrd_pkg::pl_wr_type     pl_wr;
   logic                      push_valid;
   logic                      pop;
   logic                      back_busy;

   // ---------------------------------------------------------------
   // Register block: zero wait state, write on the access phase.
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            stxfrd_pkg::REG_START_BYTE:    cfg_in.start_byte      = csr_pwdata[7:0];
            stxfrd_pkg::REG_HANDLER_COUNT: cfg_in.handler_count   = csr_pwdata[2:0];
            stxfrd_pkg::REG_HANDLER_CODE0: cfg_in.handler_code[0] = csr_pwdata[7:0];
            stxfrd_pkg::REG_HANDLER_CODE1: cfg_in.handler_code[1] = csr_pwdata[7:0];
            stxfrd_pkg::REG_HANDLER_CODE2: cfg_in.handler_code[2] = csr_pwdata[7:0];
            stxfrd_pkg::REG_HANDLER_CODE3: cfg_in.handler_code[3] = csr_pwdata[7:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         stxfrd_pkg::REG_START_BYTE:    csr_prdata[7:0] = cfg_ff.start_byte;
         stxfrd_pkg::REG_HANDLER_COUNT: csr_prdata[2:0] = cfg_ff.handler_count;
         stxfrd_pkg::REG_HANDLER_CODE0: csr_prdata[7:0] = cfg_ff.handler_code[0];
         stxfrd_pkg::REG_HANDLER_CODE1: csr_prdata[7:0] = cfg_ff.handler_code[1];
         stxfrd_pkg::REG_HANDLER_CODE2: csr_prdata[7:0] = cfg_ff.handler_code[2];
         stxfrd_pkg::REG_HANDLER_CODE3: csr_prdata[7:0] = cfg_ff.handler_code[3];
         default:                       csr_prdata      = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte    <= 8'd2;
         cfg_ff.handler_count <= '0;
         cfg_ff.handler_code  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------
   // Front end: parse bytes, check sum, match handler, push one job
   // per frame end or error beat.
   // ---------------------------------------------------------------
   stxfrd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .q_status   (q_status),
      .back_busy  (back_busy),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pl_wr      (pl_wr)
   );

   // Decouple parser from sequencer so each side stalls on its own.
   stxfrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .head_job   (head_job),
      .q_status   (q_status)
   );

   // Back end: turn each job into one status beat or a run of payload beats.
   stxfrd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_status   (q_status),
      .pl_wr      (pl_wr),
      .pop        (pop),
      .busy       (back_busy),
      .rsp_chan   (rsp_chan)
   );

endmodule
